// ===== hw/rtl/drc_pkg.sv =====
`timescale 1ns / 1ps

package drc_pkg;

   typedef struct packed {
      logic signed [15:0] top;
      logic signed [15:0] left;
      logic signed [15:0] bottom;
      logic signed [15:0] right;
   } rect_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic acc;
      logic flush_mode;
   } unit_ctl_type;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic CAUSE_REQUEST = 1'b0;
   localparam logic CAUSE_FULL    = 1'b1;

   localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [15:0] COORD_ZERO = 16'sh0000;

endpackage

// ===== hw/rtl/drc_store.sv =====
`timescale 1ns / 1ps

module drc_store #(
   parameter int DEPTH = 64,
   parameter int AW = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  drc_pkg::rect_type    wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output drc_pkg::rect_type    rd_data
);

   drc_pkg::rect_type mem [DEPTH];
   drc_pkg::rect_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/drc_scan_unit.sv =====
`timescale 1ns / 1ps

module drc_scan_unit (
   input  logic                  clock,
   input  drc_pkg::unit_ctl_type ctl,
   input  drc_pkg::rect_type     entry,
   input  drc_pkg::rect_type     rect,
   output drc_pkg::rect_type     box,
   output logic                  hit
);

   // One set of four comparators serves both the containment test and the
   // bounding box update; only the second operand changes with the mode.
   drc_pkg::rect_type box_ff;
   drc_pkg::rect_type box_in;
   drc_pkg::rect_type cmp_b;
   logic              hit_ff;
   logic              hit_in;
   logic              le_top;
   logic              le_left;
   logic              ge_bottom;
   logic              ge_right;

   always_comb begin
      cmp_b     = ctl.flush_mode ? box_ff : rect;
      le_top    = entry.top <= cmp_b.top;
      le_left   = entry.left <= cmp_b.left;
      ge_bottom = entry.bottom >= cmp_b.bottom;
      ge_right  = entry.right >= cmp_b.right;

      box_in = box_ff;
      hit_in = hit_ff;
      if (ctl.clear) begin
         box_in.top    = drc_pkg::COORD_MAX;
         box_in.left   = drc_pkg::COORD_MAX;
         box_in.bottom = drc_pkg::COORD_ZERO;
         box_in.right  = drc_pkg::COORD_ZERO;
         hit_in        = 1'b0;
      end else if (ctl.acc) begin
         if (ctl.flush_mode) begin
            box_in.top    = le_top ? entry.top : box_ff.top;
            box_in.left   = le_left ? entry.left : box_ff.left;
            box_in.bottom = ge_bottom ? entry.bottom : box_ff.bottom;
            box_in.right  = ge_right ? entry.right : box_ff.right;
         end else begin
            hit_in = hit_ff | (le_top & le_left & ge_bottom & ge_right);
         end
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
      hit_ff <= hit_in;
   end

   assign box = box_ff;
   assign hit = hit_ff;

endmodule

// ===== hw/rtl/dirty_rect_coalescer.sv =====
`timescale 1ns / 1ps

// Dirty rectangle coalescer. A transfer is taken when start is high and busy
// is low; busy then stays high until the item is done. An add or a flush
// keeps busy high through a scan of every held rectangle and a finish step,
// because the store has one read port and is scanned one entry per cycle
// through a single compare unit. An add on a full store first scans all
// RECT_SLOTS entries for the bounding box. A flush of an empty store is done
// in the cycle it is taken and never raises busy.
// A result is shown on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in the first cycle in which busy is low again; the receiver
// cannot stall it, so it must take every result in that cycle.
module dirty_rect_coalescer #(
   parameter int RECT_SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [15:0] req_rect_top,
   input  logic signed [15:0] req_rect_left,
   input  logic signed [15:0] req_rect_bottom,
   input  logic signed [15:0] req_rect_right,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_box_top,
   output logic signed [15:0] rsp_box_left,
   output logic [14:0]        rsp_box_bottom,
   output logic [14:0]        rsp_box_right,
   output logic               rsp_flush_cause
);

   localparam int CW = $clog2(RECT_SLOTS + 1);
   localparam int AW = (RECT_SLOTS > 1) ? $clog2(RECT_SLOTS) : 1;

   drc_pkg::state_type     state_ff;
   drc_pkg::state_type     state_in;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [CW-1:0]          idx_ff;
   logic [CW-1:0]          idx_in;
   logic                   rd_vld_ff;
   logic                   rd_en;
   logic                   op_ff;
   logic                   mode_ff;
   logic                   full_ff;
   drc_pkg::rect_type      rect_ff;
   drc_pkg::rect_type      req_rect;
   logic                   capture;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   drc_pkg::unit_ctl_type  ctl;
   drc_pkg::rect_type      entry;
   drc_pkg::rect_type      box;
   logic                   hit;
   logic                   store_full;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic signed [15:0]     rsp_top_ff;
   logic signed [15:0]     rsp_left_ff;
   logic [14:0]            rsp_bottom_ff;
   logic [14:0]            rsp_right_ff;
   logic                   rsp_cause_ff;

   assign req_rect.top    = req_rect_top;
   assign req_rect.left   = req_rect_left;
   assign req_rect.bottom = req_rect_bottom;
   assign req_rect.right  = req_rect_right;

   assign store_full = (count_ff == CW'(RECT_SLOTS));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];
      capture        = 1'b0;
      rsp_valid_in   = 1'b0;
      ctl.clear      = 1'b0;
      ctl.acc        = rd_vld_ff;
      ctl.flush_mode = mode_ff;
      unique case (state_ff)
         drc_pkg::ST_IDLE: begin
            if (start) begin
               capture = 1'b1;
               if (!(req_operation == drc_pkg::OP_FLUSH && count_ff == '0)) begin
                  ctl.clear = 1'b1;
                  idx_in    = '0;
                  state_in  = drc_pkg::ST_SCAN;
               end
            end
         end
         drc_pkg::ST_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = drc_pkg::ST_FINISH;
            end else begin
               rd_en  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end
         end
         drc_pkg::ST_FINISH: begin
            state_in = drc_pkg::ST_IDLE;
            if (full_ff) begin
               rsp_valid_in = 1'b1;
               wr_en        = 1'b1;
               wr_addr      = '0;
               count_in     = CW'(1);
            end else if (op_ff == drc_pkg::OP_FLUSH) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
            end else if (!hit) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         default: begin
            state_in = drc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= drc_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         op_ff   <= req_operation;
         rect_ff <= req_rect;
         full_ff <= (req_operation == drc_pkg::OP_ADD) && store_full;
         mode_ff <= (req_operation == drc_pkg::OP_FLUSH) || store_full;
      end
      if (rsp_valid_in) begin
         rsp_top_ff    <= box.top;
         rsp_left_ff   <= box.left;
         rsp_bottom_ff <= box.bottom[14:0];
         rsp_right_ff  <= box.right[14:0];
         rsp_cause_ff  <= full_ff ? drc_pkg::CAUSE_FULL : drc_pkg::CAUSE_REQUEST;
      end
   end

   drc_store #(
      .DEPTH (RECT_SLOTS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (rect_ff),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (entry)
   );

   drc_scan_unit u_unit (
      .clock (clock),
      .ctl   (ctl),
      .entry (entry),
      .rect  (rect_ff),
      .box   (box),
      .hit   (hit)
   );

   assign busy            = (state_ff != drc_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_box_top     = rsp_top_ff;
   assign rsp_box_left    = rsp_left_ff;
   assign rsp_box_bottom  = rsp_bottom_ff;
   assign rsp_box_right   = rsp_right_ff;
   assign rsp_flush_cause = rsp_cause_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RECT_SLOTS))
      else $error("rectangle count exceeds the store depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == drc_pkg::ST_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index ran past the rectangle count");

   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == drc_pkg::ST_FINISH))
      else $error("result strobe without a finished scan");

   a_empty_flush: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == drc_pkg::OP_FLUSH && count_ff == '0)
      |=> (!busy && !rsp_valid))
      else $error("flush of an empty store started work");

   a_full_add: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flush_cause == drc_pkg::CAUSE_FULL) |-> (count_ff == CW'(1)))
      else $error("full-store add did not leave one rectangle");

endmodule
